>>> hdl/v3n_pkg.sv
`default_nettype none

package v3n_pkg;

	localparam int COMP_WIDTH_DEF = 16;
	localparam int FIFO_DEPTH_DEF = 4;

endpackage

`default_nettype wire

>>> hdl/v3n_front.sv
`default_nettype none

module v3n_front #(
	parameter int COMP_WIDTH = v3n_pkg::COMP_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COMP_WIDTH-1:0]  comp_x,
	input  wire logic signed [COMP_WIDTH-1:0]  comp_y,
	input  wire logic signed [COMP_WIDTH-1:0]  comp_z,
	output logic                               sum_valid,
	input  wire logic                          sum_ready,
	output logic [2*COMP_WIDTH-1:0]            sum
);
	import v3n_pkg::*;

	localparam int W  = COMP_WIDTH;
	localparam int SW = 2 * COMP_WIDTH;

	logic          en;
	logic [W-1:0]  ux, uy, uz;
	logic [W-1:0]  ax, ay, az;
	logic [SW+1:0] sum_w;

	logic          vld_s1, vld_s2, vld_s3;
	logic [W-1:0]  abs_x_s1, abs_y_s1, abs_z_s1;
	logic [SW-1:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic [SW-1:0] sum_s3;

	assign en       = !vld_s3 || sum_ready;
	assign in_ready = en;

	assign ux = comp_x;
	assign uy = comp_y;
	assign uz = comp_z;
	assign ax = ux[W-1] ? (~ux + {{(W-1){1'b0}}, 1'b1}) : ux;
	assign ay = uy[W-1] ? (~uy + {{(W-1){1'b0}}, 1'b1}) : uy;
	assign az = uz[W-1] ? (~uz + {{(W-1){1'b0}}, 1'b1}) : uz;

	assign sum_w = {2'b00, sq_x_s2} + {2'b00, sq_y_s2} + {2'b00, sq_z_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abs_x_s1 <= ax;
			abs_y_s1 <= ay;
			abs_z_s1 <= az;
			sq_x_s2  <= abs_x_s1 * abs_x_s1;
			sq_y_s2  <= abs_y_s1 * abs_y_s1;
			sq_z_s2  <= abs_z_s1 * abs_z_s1;
			sum_s3   <= sum_w[SW-1:0];
		end
	end

	assign sum_valid = vld_s3;
	assign sum       = sum_s3;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("Accepted transaction did not enter the first stage.");

endmodule

`default_nettype wire

>>> hdl/v3n_fifo.sv
`default_nettype none

module v3n_fifo #(
	parameter int DATA_W = 2 * v3n_pkg::COMP_WIDTH_DEF,
	parameter int DEPTH  = v3n_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output logic [DATA_W-1:0]      pop_data
);
	import v3n_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("Queue count exceeds its depth.");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue count did not follow a lone push.");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("Queue count did not follow a lone pop.");

endmodule

`default_nettype wire

>>> hdl/v3n_root.sv
`default_nettype none

module v3n_root #(
	parameter int COMP_WIDTH = v3n_pkg::COMP_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    rad_valid,
	output logic                         rad_ready,
	input  wire logic [2*COMP_WIDTH-1:0] rad,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [COMP_WIDTH-1:0]        magnitude
);
	import v3n_pkg::*;

	localparam int W  = COMP_WIDTH;
	localparam int SW = 2 * COMP_WIDTH;

	logic en;

	logic [W:0]    rem_s  [W];
	logic [W-1:0]  root_s [W];
	logic [SW-1:0] rad_s  [W];
	logic [W-1:0]  vld_s;

	logic [W:0]    prev_rem  [W];
	logic [W-1:0]  prev_root [W];
	logic [SW-1:0] prev_rad  [W];
	logic [W-1:0]  prev_vld;

	assign en        = !vld_s[W-1] || out_ready;
	assign rad_ready = en;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W+2:0] cur;
		logic [W+2:0] trial;
		logic [W+2:0] diff;
		logic         ge;

		if (k == 0) begin : g_first
			assign prev_rem[k]  = '0;
			assign prev_root[k] = '0;
			assign prev_rad[k]  = rad;
			assign prev_vld[k]  = rad_valid;
		end else begin : g_next
			assign prev_rem[k]  = rem_s[k-1];
			assign prev_root[k] = root_s[k-1];
			assign prev_rad[k]  = rad_s[k-1];
			assign prev_vld[k]  = vld_s[k-1];
		end

		assign cur   = {prev_rem[k], prev_rad[k][SW-1:SW-2]};
		assign trial = {1'b0, prev_root[k], 2'b01};
		assign ge    = (cur >= trial);
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= prev_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[W:0] : cur[W:0];
				root_s[k] <= {prev_root[k][W-2:0], ge};
				rad_s[k]  <= {prev_rad[k][SW-3:0], 2'b00};
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign magnitude = root_s[W-1];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(vld_s))
		else $error("Root pipeline moved while its output was stalled.");

endmodule

`default_nettype wire

>>> hdl/vector3_euclidean_norm.sv
// Channel   Valid / Ready           Payload
// input     in_valid / in_ready     comp_x, comp_y, comp_z (signed)
// output    out_valid / out_ready   magnitude (unsigned)
//
// One transaction per cycle is sustained while the output is not stalled; a result
// passes through three front stages, the first loading at the accepting edge, the
// queue, and one root stage per result bit.
// Reset clears only valid bits, queue pointers and count; no clearing pass is needed.
// A stalled output freezes the root pipeline; the front keeps accepting while the
// queue has room, and in_ready falls once the last front stage holds a transaction
// that the full queue cannot take.
`default_nettype none

module vector3_euclidean_norm #(
	parameter int COMP_WIDTH = v3n_pkg::COMP_WIDTH_DEF,
	parameter int FIFO_DEPTH = v3n_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COMP_WIDTH-1:0]  comp_x,
	input  wire logic signed [COMP_WIDTH-1:0]  comp_y,
	input  wire logic signed [COMP_WIDTH-1:0]  comp_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [COMP_WIDTH-1:0]              magnitude
);
	import v3n_pkg::*;

	localparam int SW = 2 * COMP_WIDTH;

	logic          f_valid, f_ready;
	logic [SW-1:0] f_sum;
	logic          q_valid, q_ready;
	logic [SW-1:0] q_sum;

	v3n_front #(
		.COMP_WIDTH(COMP_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.comp_x    (comp_x),
		.comp_y    (comp_y),
		.comp_z    (comp_z),
		.sum_valid (f_valid),
		.sum_ready (f_ready),
		.sum       (f_sum)
	);

	v3n_fifo #(
		.DATA_W (SW),
		.DEPTH  (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_sum),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_sum)
	);

	v3n_root #(
		.COMP_WIDTH(COMP_WIDTH)
	) u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.rad_valid (q_valid),
		.rad_ready (q_ready),
		.rad       (q_sum),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.magnitude (magnitude)
	);

endmodule

`default_nettype wire

>>> dv/vector3_euclidean_norm_test.sv
`default_nettype none

module vector3_euclidean_norm_test;

	localparam int W = v3n_pkg::COMP_WIDTH_DEF;
	localparam int COMP_MIN = -(2 ** (W - 1));
	localparam int COMP_MAX = 2 ** (W - 1) - 1;
	localparam int ITEMS_PER_PHASE = 330;

	typedef struct {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic signed [W-1:0] z;
		bit                  drain;
	} vec_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic signed [W-1:0] comp_x = '0;
	logic signed [W-1:0] comp_y = '0;
	logic signed [W-1:0] comp_z = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [W-1:0]        magnitude;

	vec_item_t    pending_vectors[$];
	logic [W-1:0] expected_lengths[$];

	int send_idle_pct = 29;
	int recv_idle_pct = 86;
	int sent_count = 0;
	int checked_count = 0;
	int failure_count = 0;
	logic [W-1:0] peak_length = '0;

	vector3_euclidean_norm #(
		.COMP_WIDTH(W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.comp_x(comp_x),
		.comp_y(comp_y),
		.comp_z(comp_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.magnitude(magnitude)
	);

	always #5 clk = ~clk;

	function automatic logic [W:0] abs_component(input logic signed [W-1:0] c);
		if (c[W-1]) begin
			return ((W + 1)'(1) << W) - {1'b0, c};
		end
		return {1'b0, c};
	endfunction

	function automatic logic [W-1:0] vector_length(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y, input logic signed [W-1:0] z);
		logic [W:0]     ax;
		logic [W:0]     ay;
		logic [W:0]     az;
		logic [2*W+1:0] remainder;
		logic [2*W+1:0] root;
		logic [2*W+1:0] probe;
		ax = abs_component(x);
		ay = abs_component(y);
		az = abs_component(z);
		remainder = ax * ax + ay * ay + az * az;
		root = '0;
		probe = (2 * W + 2)'(1) << (2 * W);
		for (int i = 0; i <= W; i++) begin
			if (remainder >= root + probe) begin
				remainder = remainder - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[W-1:0];
	endfunction

	function automatic vec_item_t make_vector(input int x, input int y, input int z,
		input bit drain);
		vec_item_t v;
		v.x = W'(x);
		v.y = W'(y);
		v.z = W'(z);
		v.drain = drain;
		return v;
	endfunction

	function automatic vec_item_t random_vector();
		int quad [5][3];
		int c [3];
		int mode;
		int q;
		int k;
		mode = $urandom_range(0, 9);
		quad = '{'{1, 2, 2}, '{2, 3, 6}, '{1, 4, 8}, '{2, 6, 9}, '{4, 4, 7}};
		q = $urandom_range(0, 4);
		k = $urandom_range(1, COMP_MAX / 9);
		for (int i = 0; i < 3; i++) begin
			case (mode)
				0, 1, 2, 3: c[i] = int'($signed(W'($urandom)));
				4, 5: c[i] = $urandom_range(0, 31) - 16;
				6: begin
					case ($urandom_range(0, 5))
						0: c[i] = COMP_MIN;
						1: c[i] = COMP_MAX;
						2: c[i] = COMP_MIN + $urandom_range(1, 8);
						3: c[i] = COMP_MAX - $urandom_range(1, 8);
						4: c[i] = -1;
						default: c[i] = $urandom_range(0, 1);
					endcase
				end
				7: c[i] = (i == q % 3) ? int'($signed(W'($urandom))) : 0;
				default: begin
					c[i] = quad[q][i] * k + $urandom_range(0, 2) - 1;
					if ($urandom_range(0, 1) == 1) begin
						c[i] = -c[i];
					end
				end
			endcase
		end
		return make_vector(c[0], c[1], c[2], $urandom_range(0, 99) == 0);
	endfunction

	task automatic log_failure(input string what, input logic [W-1:0] expected_value,
		input logic [W-1:0] actual_value);
		failure_count++;
		if (failure_count <= 10) begin
			$display("%s: expected %0d, got %0d", what, expected_value, actual_value);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			comp_x <= '0;
			comp_y <= '0;
			comp_z <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_lengths.push_back(vector_length(comp_x, comp_y, comp_z));
				sent_count++;
			end
			if (!in_valid || in_ready) begin
				if (pending_vectors.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
					&& !(pending_vectors[0].drain && expected_lengths.size() != 0)) begin
					in_valid <= 1'b1;
					comp_x <= pending_vectors[0].x;
					comp_y <= pending_vectors[0].y;
					comp_z <= pending_vectors[0].z;
					void'(pending_vectors.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lengths.size() == 0) begin
					log_failure("Result transaction with nothing expected", '0, magnitude);
				end else begin
					if (magnitude !== expected_lengths[0]) begin
						log_failure("Magnitude mismatch", expected_lengths[0], magnitude);
					end
					void'(expected_lengths.pop_front());
				end
				if (magnitude > peak_length) begin
					peak_length = magnitude;
				end
				checked_count++;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		for (int phase = 0; phase < 3; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				pending_vectors.push_back(make_vector(0, 0, 0, 0));
				pending_vectors.push_back(make_vector(COMP_MIN, COMP_MIN, COMP_MIN, 0));
				pending_vectors.push_back(make_vector(COMP_MAX, COMP_MAX, COMP_MAX, 0));
				pending_vectors.push_back(make_vector(COMP_MIN, 0, 0, 0));
				pending_vectors.push_back(make_vector(0, COMP_MIN, 0, 0));
				pending_vectors.push_back(make_vector(0, 0, COMP_MIN, 0));
				pending_vectors.push_back(make_vector(COMP_MAX, 0, 0, 0));
				pending_vectors.push_back(make_vector(0, COMP_MAX, 0, 0));
				pending_vectors.push_back(make_vector(0, 0, COMP_MAX, 0));
				pending_vectors.push_back(make_vector(COMP_MIN, COMP_MAX, COMP_MIN, 0));
				pending_vectors.push_back(make_vector(COMP_MAX, COMP_MIN, COMP_MAX, 0));
				pending_vectors.push_back(make_vector(COMP_MIN, COMP_MIN, 0, 0));
				pending_vectors.push_back(make_vector(3, 4, 0, 1));
				pending_vectors.push_back(make_vector(2, 3, 6, 0));
				pending_vectors.push_back(make_vector(1, 2, 2, 0));
				pending_vectors.push_back(make_vector(-3, -4, 12, 0));
				pending_vectors.push_back(make_vector(-1, -1, -1, 0));
				pending_vectors.push_back(make_vector(1, 0, 0, 0));
				pending_vectors.push_back(make_vector(0, 1, 1, 0));
				pending_vectors.push_back(make_vector(1, 1, 1, 0));
			end
			repeat (ITEMS_PER_PHASE) pending_vectors.push_back(random_vector());
			while (pending_vectors.size() != 0 || in_valid || expected_lengths.size() != 0) begin
				@(negedge clk);
			end
		end
		repeat (W + 12) @(negedge clk);
		$display("Checked %0d vector lengths from %0d transactions over three pacing phases,",
			checked_count, sent_count);
		$display("including extreme, zero and exact-root vectors; largest length seen %0d.",
			peak_length);
		if (failure_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
